// File: sv/srx_pkg.sv
// ----------------------------------------------------------------------------
// srx_pkg
// shared types, constants and the crc-8 fold for the sync packet receiver
// ----------------------------------------------------------------------------
`default_nettype none

package srx_pkg;

	// packet buffer size in bytes (4 to 256)
	localparam int BUFFER_BYTES = 64;
	localparam int BUF_AW       = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

	localparam logic [7:0] SYNC_PATTERN = 8'h55;
	localparam logic [7:0] CRC_POLY     = 8'h8C;
	localparam logic [7:0] HUNT         = 8'hFF;
	localparam logic [3:0] NIB_MASK     = 4'h0F;

	typedef enum logic [1:0] {
		FUNC_BYTE  = 2'd0,
		FUNC_POLL  = 2'd1,
		FUNC_QUERY = 2'd2,
		FUNC_READ  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		RC_OK       = 3'd0,
		RC_BUSY     = 3'd1,
		RC_FRAME    = 3'd2,
		RC_BYTE_OVR = 3'd3,
		RC_BUF_OVR  = 3'd4,
		RC_CRC      = 3'd5
	} rc_t;

	typedef enum logic [1:0] {
		REG_OWN_ADDR   = 2'd0,
		REG_BCAST_ADDR = 2'd1
	} cfg_reg_t;

	// word waiting between the state stage and the output register
	typedef struct packed {
		logic valid;
		rc_t  code;
		logic is_read;
		logic in_range;
	} s1_t;

	// store access request
	typedef struct packed {
		logic              we;
		logic [BUF_AW-1:0] waddr;
		logic [7:0]        wdata;
		logic              re;
		logic [BUF_AW-1:0] raddr;
	} ram_req_t;

	// reflected crc-8, one byte, lsb first
	function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] v;
		v = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			if (v[0]) begin
				v = (v >> 1) ^ CRC_POLY;
			end else begin
				v = v >> 1;
			end
		end
		return v;
	endfunction

	localparam logic [7:0] CRC_SYNC = crc8_fold(8'h00, SYNC_PATTERN);

endpackage

`default_nettype wire

// File: sv/srx_ram.sv
// ----------------------------------------------------------------------------
// srx_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module srx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: sv/srx_core.sv
// ----------------------------------------------------------------------------
// srx_core
// packet state, crc update, poll decode and the result stage register
// ----------------------------------------------------------------------------
`default_nettype none

module srx_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [1:0]        func,
	input  wire logic [7:0]        rx_byte,
	input  wire logic              frame_error,
	input  wire logic              data_overrun,
	input  wire logic [5:0]        read_index,
	input  wire logic [3:0]        own_address,
	input  wire logic [3:0]        broadcast_address,
	input  wire logic              s1_take,
	output logic                   in_stall,
	output srx_pkg::s1_t           s1,
	output srx_pkg::ram_req_t      ram_req
);

	import srx_pkg::*;

	logic [7:0] count_q;
	logic [7:0] crc_q;
	logic       fe_q;
	logic       ov_q;
	logic [7:0] addr_q;
	logic [7:0] len_q;

	logic       accept;
	func_t      fn;
	logic       hunting;
	logic       line_err;
	logic       store_byte;
	logic [8:0] need;
	logic [8:0] count9;
	logic       poll_busy;
	logic       poll_ovf;
	logic       addr_hit;
	rc_t        poll_code;
	rc_t        new_code;

	assign in_stall = s1.valid && !s1_take;
	assign accept   = in_valid && !in_stall;
	assign fn       = func_t'(func);
	assign hunting  = (count_q == HUNT);
	assign line_err = frame_error || data_overrun;

	// byte goes into the packet after sync
	assign store_byte = accept && (fn == FUNC_BYTE) && !line_err && !hunting;

	// store write at the current count, read for buffer reads
	always_comb begin
		ram_req.we    = store_byte && ({1'b0, count_q} < 9'(BUFFER_BYTES));
		ram_req.waddr = count_q[BUF_AW-1:0];
		ram_req.wdata = rx_byte;
		ram_req.re    = accept && (fn == FUNC_READ);
		ram_req.raddr = BUF_AW'(read_index);
	end

	// poll decode from the header shadows and the count
	assign need      = {1'b0, len_q} + 9'd3;
	assign count9    = {1'b0, count_q};
	assign poll_busy = hunting || (count_q < 8'd2) || (count9 < need);
	assign poll_ovf  = (count9 > need) || (need > 9'(BUFFER_BYTES));
	assign addr_hit  = ((addr_q[3:0] & NIB_MASK) == own_address) ||
	                   ((addr_q[3:0] & NIB_MASK) == broadcast_address);

	always_comb begin
		if (fe_q) begin
			poll_code = RC_FRAME;
		end else if (ov_q) begin
			poll_code = RC_BYTE_OVR;
		end else if (poll_busy) begin
			poll_code = RC_BUSY;
		end else if (poll_ovf) begin
			poll_code = RC_BUF_OVR;
		end else if (crc_q != 8'h00) begin
			poll_code = RC_CRC;
		end else if (!addr_hit) begin
			poll_code = RC_BUSY;
		end else begin
			poll_code = RC_OK;
		end
	end

	always_comb begin
		case (fn)
			FUNC_POLL:  new_code = poll_code;
			FUNC_QUERY: new_code = hunting ? RC_OK : RC_BUF_OVR;
			default:    new_code = RC_OK;
		endcase
	end

	// packet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= HUNT;
			crc_q   <= CRC_SYNC;
			fe_q    <= 1'b0;
			ov_q    <= 1'b0;
		end else if (accept) begin
			case (fn)
				FUNC_BYTE: begin
					if (line_err) begin
						if (frame_error) begin
							fe_q <= 1'b1;
						end
						if (data_overrun) begin
							ov_q <= 1'b1;
						end
					end else if (hunting) begin
						if (rx_byte == SYNC_PATTERN) begin
							count_q <= 8'd0;
							crc_q   <= CRC_SYNC;
						end
					end else begin
						crc_q   <= crc8_fold(crc_q, rx_byte);
						count_q <= count_q + 8'd1;
					end
				end
				FUNC_POLL: begin
					fe_q <= 1'b0;
					ov_q <= 1'b0;
					if (!fe_q && !ov_q && !poll_busy) begin
						count_q <= HUNT;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// header shadows of store entries 0 and 1
	always_ff @(posedge clk) begin
		if (store_byte && (count_q == 8'd0)) begin
			addr_q <= rx_byte;
		end
		if (store_byte && (count_q == 8'd1)) begin
			len_q <= rx_byte;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1 <= '0;
		end else if (accept) begin
			s1.valid    <= (fn != FUNC_BYTE);
			s1.code     <= new_code;
			s1.is_read  <= (fn == FUNC_READ);
			s1.in_range <= ({3'b000, read_index} < 9'(BUFFER_BYTES));
		end else if (s1_take) begin
			s1.valid <= 1'b0;
		end
	end

	// a poll always leaves both error flags clear
	a_poll_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (fn == FUNC_POLL) |=> !fe_q && !ov_q)
		else $error("poll did not clear error flags");

	// no store write while hunting for sync
	a_no_write_hunting: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.we |-> !hunting)
		else $error("store written while hunting");

	// a word stuck in the result stage keeps its contents
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1.valid && !s1_take |=> s1.valid && $stable(s1))
		else $error("result stage changed while blocked");

	// sync resets the crc to its seed
	a_sync_seed: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (fn == FUNC_BYTE) && !line_err && hunting && (rx_byte == SYNC_PATTERN)
		|=> (count_q == 8'd0) && (crc_q == CRC_SYNC))
		else $error("sync did not reseed the crc");

endmodule

`default_nettype wire

// File: sv/sync_crc8_packet_receiver_top.sv
// ----------------------------------------------------------------------------
// sync_crc8_packet_receiver_top
// sync-framed uart packet receiver with crc-8 check, poll, query and read
// ----------------------------------------------------------------------------
// One word is accepted per clock while in_stall is low. Byte words update
// the packet state in the cycle they are taken and give no result; poll,
// query and read words give one result, which passes through the result
// stage, which also covers the registered read of the packet buffer ram,
// and then into the output register. Input stall rises only when both the
// result stage and the output register hold words and the output is
// stalled. The address and length bytes are also kept in shadow registers
// so a poll needs no buffer read.
`default_nettype none

module sync_crc8_packet_receiver_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// input channel
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] func,
	input  wire logic [7:0] rx_byte,
	input  wire logic       frame_error,
	input  wire logic       data_overrun,
	input  wire logic [5:0] read_index,
	// result channel
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [2:0]      result_code,
	output logic [7:0]      read_data,
	// configuration write channel
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [3:0] cfg_data
);

	import srx_pkg::*;

	logic       own_q;
	logic [3:0] own_addr_q;
	logic [3:0] bcast_addr_q;
	s1_t        s1;
	ram_req_t   ram_req;
	logic       s1_take;
	logic [7:0] ram_rdata;
	logic       out_valid_q;
	rc_t        out_code_q;
	logic [7:0] out_data_q;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;
	assign own_q     = (cfg_index == REG_OWN_ADDR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q   <= 4'd1;
			bcast_addr_q <= 4'd15;
		end else if (cfg_valid && cfg_ready) begin
			if (own_q) begin
				own_addr_q <= cfg_data;
			end else if (cfg_index == REG_BCAST_ADDR) begin
				bcast_addr_q <= cfg_data;
			end
		end
	end

	srx_core u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.func              (func),
		.rx_byte           (rx_byte),
		.frame_error       (frame_error),
		.data_overrun      (data_overrun),
		.read_index        (read_index),
		.own_address       (own_addr_q),
		.broadcast_address (bcast_addr_q),
		.s1_take           (s1_take),
		.in_stall          (in_stall),
		.s1                (s1),
		.ram_req           (ram_req)
	);

	srx_ram #(
		.WIDTH (8),
		.DEPTH (BUFFER_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	// output register, loads when empty or being taken
	assign s1_take = s1.valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take) begin
			out_code_q <= s1.code;
			out_data_q <= (s1.is_read && s1.in_range) ? ram_rdata : 8'h00;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_code = out_code_q;
	assign read_data   = out_data_q;

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sync-framed crc-8 packet receiver
// ----------------------------------------------------------------------------
// Words are driven on the input channel and every accepted word is run
// through a local copy of the receiver state: sync hunt, byte count, packet
// store, crc accumulator and the sticky line-error flags. Poll, query and
// read words queue the status they should produce, and each word taken from
// the result channel is compared with the oldest queued status. Directed
// tests cover idle hunting, line errors, short and full-size frames, count
// rollover into hunting and address matching. A random phase then sends
// mostly well-formed frames with random content, mixed with broken frames
// and stray words, and moves the address registers every eighth iteration.
// ----------------------------------------------------------------------------

module tb;
	import srx_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 4;

	typedef struct {
		rc_t        code;
		logic [7:0] data;
	} status_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] func = FUNC_BYTE;
	logic [7:0] rx_byte = 8'h00;
	logic       frame_error = 1'b0;
	logic       data_overrun = 1'b0;
	logic [5:0] read_index = 6'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] result_code;
	logic [7:0] read_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = REG_OWN_ADDR;
	logic [3:0] cfg_data = 4'd0;

	// expected status of every poll, query and read still in flight
	status_t pending_status[$];

	// receiver state as the bench tracks it
	logic [7:0] rx_count = HUNT;
	logic [7:0] crc_acc = CRC_SYNC;
	bit   [7:0] pkt_buf [BUFFER_BYTES];
	bit         buf_written [BUFFER_BYTES];
	logic       flag_frame = 1'b0;
	logic       flag_ovr = 1'b0;
	logic [3:0] addr_own = 4'd1;
	logic [3:0] addr_bcast = 4'd15;

	int  errors = 0;
	int  words_sent = 0;
	int  cycles = 0;
	bit  quiet = 1'b0;

	sync_crc8_packet_receiver_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.rx_byte      (rx_byte),
		.frame_error  (frame_error),
		.data_overrun (data_overrun),
		.read_index   (read_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_code  (result_code),
		.read_data    (read_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** sync_crc8_packet_receiver_top: FAILED **");
			$finish;
		end
	end

	// result side backpressure, switched off during the quiet stretch
	always @(posedge clk) begin
		out_stall <= !quiet && ($urandom_range(99) < 32);
	end

	// reflected crc-8, data bits taken lsb first
	function automatic logic [7:0] crc_step(logic [7:0] acc, logic [7:0] b);
		logic [7:0] r;
		logic       fb;
		r = acc;
		for (int k = 0; k < 8; k++) begin
			fb = r[0] ^ b[k];
			r = {1'b0, r[7:1]};
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	// poll: clear the sticky flags, then judge the frame held so far
	function automatic rc_t poll_outcome();
		logic       fe;
		logic       ov;
		int         cnt;
		int         need;
		logic [3:0] nib;
		fe = flag_frame;
		ov = flag_ovr;
		cnt = int'(rx_count);
		need = int'(pkt_buf[1]) + 3;
		flag_frame = 1'b0;
		flag_ovr = 1'b0;
		if (fe) return RC_FRAME;
		if (ov) return RC_BYTE_OVR;
		if (cnt == HUNT || cnt < need) return RC_BUSY;
		rx_count = HUNT;
		if (cnt > need || need > BUFFER_BYTES) return RC_BUF_OVR;
		if (crc_acc != 8'h00) return RC_CRC;
		nib = pkt_buf[0][3:0] & NIB_MASK;
		if (nib != addr_own && nib != addr_bcast) return RC_BUSY;
		return RC_OK;
	endfunction

	// apply one accepted word to the tracked state, queue its status if any
	function automatic void advance_model(func_t f, logic [7:0] b, logic fe, logic ov,
		logic [5:0] idx);
		status_t s;
		s.code = RC_OK;
		s.data = 8'h00;
		case (f)
			FUNC_BYTE: begin
				if (fe || ov) begin
					if (fe) flag_frame = 1'b1;
					if (ov) flag_ovr = 1'b1;
				end else if (rx_count == HUNT) begin
					if (b == SYNC_PATTERN) begin
						rx_count = 8'd0;
						crc_acc = crc_step(8'h00, SYNC_PATTERN);
					end
				end else begin
					crc_acc = crc_step(crc_acc, b);
					if (rx_count < BUFFER_BYTES) begin
						pkt_buf[rx_count[BUF_AW-1:0]] = b;
						buf_written[rx_count[BUF_AW-1:0]] = 1'b1;
					end
					rx_count = rx_count + 8'd1;
				end
			end
			FUNC_POLL: s.code = poll_outcome();
			FUNC_QUERY: s.code = (rx_count != HUNT) ? RC_BUF_OVR : RC_OK;
			default: begin
				if (idx < BUFFER_BYTES) s.data = pkt_buf[idx];
			end
		endcase
		if (f != FUNC_BYTE) pending_status.push_back(s);
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	// compare each result word with the oldest expected status
	always @(posedge clk) begin : check_results
		status_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_status.size() == 0) begin
				report_mismatch("result word with nothing pending, code",
					int'(result_code), 0);
			end else begin
				want = pending_status.pop_front();
				if (result_code !== want.code) begin
					report_mismatch("result_code", int'(result_code), int'(want.code));
				end
				if (read_data !== want.data) begin
					report_mismatch("read_data", int'(read_data), int'(want.data));
				end
			end
		end
	end

	// drive one word, optionally after a random gap, and wait until taken
	task automatic send_word(func_t f, logic [7:0] b, logic fe, logic ov, logic [5:0] idx);
		if (!quiet) begin
			while ($urandom_range(99) < 32) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		func <= f;
		rx_byte <= b;
		frame_error <= fe;
		data_overrun <= ov;
		read_index <= idx;
		do @(posedge clk); while (in_stall);
		advance_model(f, b, fe, ov, idx);
		words_sent++;
	endtask

	task automatic send_byte(logic [7:0] b);
		send_word(FUNC_BYTE, b, 1'b0, 1'b0, 6'($urandom_range(63)));
	endtask

	// poll or query; the byte fields are don't-care and get random values
	task automatic send_cmd(func_t f);
		send_word(f, 8'($urandom_range(255)), 1'($urandom_range(1)),
			1'($urandom_range(1)), 6'($urandom_range(63)));
	endtask

	// read a random store entry that has been written, else fall back to a query
	task automatic send_read();
		int start;
		int pos;
		start = $urandom_range(BUFFER_BYTES - 1);
		pos = -1;
		for (int k = 0; k < BUFFER_BYTES && pos < 0; k++) begin
			if (buf_written[(start + k) % BUFFER_BYTES]) pos = (start + k) % BUFFER_BYTES;
		end
		if (pos < 0) begin
			send_cmd(FUNC_QUERY);
		end else begin
			send_word(FUNC_READ, 8'($urandom_range(255)), 1'($urandom_range(1)),
				1'($urandom_range(1)), pos[5:0]);
		end
	endtask

	// sync, header, payload and crc; a poll slips in after early_at payload bytes
	task automatic send_frame(logic [7:0] addr, int len, logic [7:0] crc_flip, int early_at);
		logic [7:0] acc;
		logic [7:0] b;
		acc = crc_step(8'h00, SYNC_PATTERN);
		send_byte(SYNC_PATTERN);
		acc = crc_step(acc, addr);
		send_byte(addr);
		acc = crc_step(acc, len[7:0]);
		send_byte(len[7:0]);
		for (int i = 0; i < len; i++) begin
			if (i == early_at) send_cmd(FUNC_POLL);
			b = 8'($urandom_range(255));
			acc = crc_step(acc, b);
			send_byte(b);
		end
		send_byte(acc ^ crc_flip);
	endtask

	// drop valid, let every pending status come back, then let the block settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_status.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, logic [3:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (r == REG_OWN_ADDR) addr_own = v;
		else addr_bcast = v;
	endtask

	// hunting state, stray bytes and sticky line errors
	task automatic test_idle_hunt();
		send_cmd(FUNC_POLL);
		send_cmd(FUNC_QUERY);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hAA);
		send_word(FUNC_BYTE, SYNC_PATTERN, 1'b1, 1'b0, 6'd0);
		send_cmd(FUNC_QUERY);
		send_cmd(FUNC_POLL);
		send_word(FUNC_BYTE, 8'h3C, 1'b0, 1'b1, 6'd63);
		send_cmd(FUNC_POLL);
		send_word(FUNC_BYTE, 8'hC3, 1'b1, 1'b1, 6'd21);
		send_cmd(FUNC_POLL);
		send_cmd(FUNC_POLL);
	endtask

	// short frames: matches, mismatches, bad crc, trailing byte, early poll
	task automatic test_short_frames();
		send_frame(8'h01, 0, 8'h00, -1);
		send_cmd(FUNC_POLL);
		send_frame(8'hFF, 2, 8'h00, -1);
		send_cmd(FUNC_POLL);
		send_frame(8'h37, 1, 8'h00, -1);
		send_cmd(FUNC_POLL);
		send_frame(8'h21, 3, 8'h80, -1);
		send_cmd(FUNC_POLL);
		send_frame(8'hA1, 1, 8'h00, -1);
		send_byte(8'h5A);
		send_cmd(FUNC_POLL);
		send_frame(8'h01, 3, 8'h00, 1);
		send_cmd(FUNC_POLL);
		for (int i = 0; i < 4; i++) begin
			send_word(FUNC_READ, 8'h00, 1'b0, 1'b0, i[5:0]);
		end
	endtask

	// full buffer, one byte past it, and byte count rollover into hunting
	task automatic test_long_frames();
		send_frame(8'hE1, BUFFER_BYTES - 3, 8'h00, -1);
		send_cmd(FUNC_POLL);
		send_word(FUNC_READ, 8'h00, 1'b0, 1'b0, 6'd63);
		send_word(FUNC_READ, 8'h00, 1'b0, 1'b0, 6'd32);
		send_word(FUNC_READ, 8'h00, 1'b0, 1'b0, 6'd0);
		send_frame(8'h0F, BUFFER_BYTES - 2, 8'h00, -1);
		send_cmd(FUNC_POLL);
		// 255 bytes after sync bring the count back to hunting
		send_byte(SYNC_PATTERN);
		send_cmd(FUNC_QUERY);
		repeat (255) send_byte(8'($urandom_range(255)));
		send_cmd(FUNC_QUERY);
		send_cmd(FUNC_POLL);
		send_word(FUNC_READ, 8'h00, 1'b0, 1'b0, 6'd63);
	endtask

	// address registers at their extremes and a plain setting
	task automatic test_address_regs();
		logic [3:0] own_v [3];
		logic [3:0] bcast_v [3];
		own_v = '{4'd0, 4'd15, 4'd10};
		bcast_v = '{4'd0, 4'd15, 4'd5};
		for (int p = 0; p < 3; p++) begin
			write_reg(REG_OWN_ADDR, own_v[p]);
			write_reg(REG_BCAST_ADDR, bcast_v[p]);
			send_frame({4'h9, own_v[p]}, 1, 8'h00, -1);
			send_cmd(FUNC_POLL);
			send_frame({4'h3, bcast_v[p]}, 0, 8'h00, -1);
			send_cmd(FUNC_POLL);
			send_frame({4'h6, own_v[p] ^ 4'h3}, 2, 8'h00, -1);
			send_cmd(FUNC_POLL);
		end
	endtask

	// mostly well-formed frames with random content, plus broken frames and noise
	task automatic test_random();
		int         stop_at;
		int         iter;
		int         r;
		int         len;
		int         flaw;
		logic [7:0] addr;
		stop_at = words_sent + 400;
		iter = 0;
		while (words_sent < stop_at) begin
			quiet = (words_sent > stop_at - 280) && (words_sent < stop_at - 160);
			if (iter % 8 == 7) begin
				r = $urandom_range(3);
				write_reg(r[0] ? REG_BCAST_ADDR : REG_OWN_ADDR,
					r[1] ? 4'($urandom_range(15)) : ($urandom_range(1) ? 4'd15 : 4'd0));
			end
			iter++;
			r = $urandom_range(99);
			if (r < 65) begin
				addr = 8'($urandom_range(255));
				case ($urandom_range(3))
					0: addr[3:0] = addr_own;
					1: addr[3:0] = addr_bcast;
					default: ;
				endcase
				r = $urandom_range(99);
				if (r < 80) len = $urandom_range(8);
				else if (r < 94) len = $urandom_range(61, 9);
				else len = $urandom_range(70, 62);
				flaw = $urandom_range(99);
				send_frame(addr, len, (flaw < 12) ? 8'($urandom_range(255, 1)) : 8'h00,
					(flaw >= 12 && flaw < 20) ? $urandom_range(len) : -1);
				if (flaw >= 20 && flaw < 28) send_byte(8'($urandom_range(255)));
				if ($urandom_range(3) == 0) send_cmd(FUNC_QUERY);
				send_cmd(FUNC_POLL);
				repeat ($urandom_range(3)) send_read();
			end else if (r < 80) begin
				// truncated frame
				send_byte(SYNC_PATTERN);
				repeat ($urandom_range(4)) send_byte(8'($urandom_range(255)));
				send_cmd(FUNC_POLL);
			end else begin
				repeat ($urandom_range(4, 1)) begin
					case ($urandom_range(3))
						0: send_word(FUNC_BYTE, 8'($urandom_range(255)),
							$urandom_range(99) < 15, $urandom_range(99) < 15,
							6'($urandom_range(63)));
						1: send_cmd(FUNC_POLL);
						2: send_cmd(FUNC_QUERY);
						default: send_read();
					endcase
				end
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_hunt();
		test_short_frames();
		test_long_frames();
		test_address_regs();
		test_random();
		wait_idle();
		if (errors == 0) begin
			$display("** sync_crc8_packet_receiver_top: PASSED **");
		end else begin
			$display("** sync_crc8_packet_receiver_top: FAILED **");
		end
		$finish;
	end

endmodule

// File: sync_crc8_packet_receiver_top.f
sv/srx_pkg.sv
sv/srx_ram.sv
sv/srx_core.sv
sv/sync_crc8_packet_receiver_top.sv
bench/tb.sv
